>>> hdl/ett_pkg.sv
`default_nettype none
package ett_pkg;

  // ring count, kept inside the range the sin/cos table covers
  localparam int SEGMENTS = 10;
  localparam int SEG      = (SEGMENTS < 3) ? 3 : ((SEGMENTS > 10) ? 10 : SEGMENTS);
  localparam int SEG_W    = $clog2(SEG + 2);
  localparam int VTX_PER_SEG = 6;

  // sin/cos table: one block per ring count from 3 to 10
  localparam int TAB_N   = 52;
  localparam int TAB_W   = $clog2(TAB_N);
  localparam int TAB_OFF = (SEG - 1) * SEG / 2 - 3;

  // field and datapath widths
  localparam int POS_W = 24;
  localparam int R_W   = 20;
  localparam int COL_W = 24;
  localparam int SCL_W = 16;
  localparam int NRM_W = 16;
  localparam int CFG_W = 24;
  localparam int D_W   = 25;
  localparam int V_W   = 26;
  localparam int SUM_W = 52;
  localparam int LEN_W = 32;
  localparam int U_W   = 32;
  localparam int DIR_W = 35;
  localparam int Q_W   = 31;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_TOP    = 2'd2,
    REG_BOTTOM = 2'd3
  } cfg_reg_t;

  localparam logic signed [15:0] COS_TAB [TAB_N] = '{
    16'sd16384, -16'sd8192, -16'sd8192,
    16'sd16384, 16'sd0, -16'sd16384, 16'sd0,
    16'sd16384, 16'sd5063, -16'sd13255, -16'sd13255, 16'sd5063,
    16'sd16384, 16'sd8192, -16'sd8192, -16'sd16384, -16'sd8192, 16'sd8192,
    16'sd16384, 16'sd10215, -16'sd3646, -16'sd14761, -16'sd14761, -16'sd3646, 16'sd10215,
    16'sd16384, 16'sd11585, 16'sd0, -16'sd11585, -16'sd16384, -16'sd11585, 16'sd0,
    16'sd11585,
    16'sd16384, 16'sd12551, 16'sd2845, -16'sd8192, -16'sd15396, -16'sd15396, -16'sd8192,
    16'sd2845, 16'sd12551,
    16'sd16384, 16'sd13255, 16'sd5063, -16'sd5063, -16'sd13255, -16'sd16384, -16'sd13255,
    -16'sd5063, 16'sd5063, 16'sd13255
  };

  localparam logic signed [15:0] SIN_TAB [TAB_N] = '{
    16'sd0, 16'sd14189, -16'sd14189,
    16'sd0, 16'sd16384, 16'sd0, -16'sd16384,
    16'sd0, 16'sd15582, 16'sd9630, -16'sd9630, -16'sd15582,
    16'sd0, 16'sd14189, 16'sd14189, 16'sd0, -16'sd14189, -16'sd14189,
    16'sd0, 16'sd12810, 16'sd15973, 16'sd7109, -16'sd7109, -16'sd15973, -16'sd12810,
    16'sd0, 16'sd11585, 16'sd16384, 16'sd11585, 16'sd0, -16'sd11585, -16'sd16384,
    -16'sd11585,
    16'sd0, 16'sd10531, 16'sd16135, 16'sd14189, 16'sd5604, -16'sd5604, -16'sd14189,
    -16'sd16135, -16'sd10531,
    16'sd0, 16'sd9630, 16'sd15582, 16'sd15582, 16'sd9630, 16'sd0, -16'sd9630,
    -16'sd15582, -16'sd15582, -16'sd9630
  };

  // one ring point: offset direction and unit normal
  typedef struct packed {
    logic [2:0][DIR_W-1:0] dir;
    logic [2:0][NRM_W-1:0] nrm;
  } ring_t;

  // tube end points and radii
  typedef struct packed {
    logic [2:0][POS_W-1:0] st;
    logic [2:0][POS_W-1:0] en;
    logic [R_W-1:0]        r0;
    logic [R_W-1:0]        r1;
  } hdr_t;

  typedef struct packed {
    logic start;
    logic frac_hi;
  } unit_req_t;

  typedef struct packed {
    logic ring_push;
    logic hdr_push;
  } q_push_t;

  typedef struct packed {
    logic ring_full;
    logic hdr_full;
  } q_full_t;

  typedef struct packed {
    logic ring_pop;
    logic hdr_pop;
  } q_pop_t;

  typedef struct packed {
    logic ring_empty;
    logic hdr_valid;
  } q_avail_t;

  typedef enum logic [2:0] {
    U_IDLE, U_SQ, U_RINIT, U_ROOT, U_DLOAD, U_DIV, U_DONE
  } unit_state_t;

  typedef enum logic [3:0] {
    F_IDLE, F_AXIS, F_CMP, F_SIDE, F_UP, F_RSCALE, F_RMUL, F_RADD, F_RNORM,
    F_RPUSH, F_HDR
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE, B_SECOND, B_EMIT
  } back_state_t;

  // round half away from zero, dropping n fraction bits
  function automatic logic signed [63:0] rnd64(input logic signed [63:0] v,
                                               input int unsigned n);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (n - 1))) >> n;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [63:0] v);
    if (v > 64'(POS_MAX)) return POS_MAX;
    if (v < 64'(POS_MIN)) return POS_MIN;
    return v[POS_W-1:0];
  endfunction

  function automatic logic [TAB_W-1:0] tab_idx(input logic [SEG_W-1:0] k);
    return TAB_W'(TAB_OFF) + TAB_W'(k);
  endfunction

endpackage
`default_nettype wire

>>> hdl/ett_unitize.sv
`default_nettype none
module ett_unitize
  import ett_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire unit_req_t             req,
  input  wire logic [2:0][V_W-1:0]   vec_in,
  output logic                       done,
  output logic [SUM_W-1:0]           sum_sq,
  output logic [2:0][U_W-1:0]        vec_out
);

  unit_state_t state;
  logic [1:0]            idx;
  logic [2:0][V_W-2:0]   mag;
  logic [2:0]            neg;
  logic                  fhi;
  logic [SUM_W-1:0]      sum;
  logic [63:0]           x, r, b;
  logic [LEN_W-1:0]      len;
  logic [LEN_W-1:0]      rem;
  logic [Q_W-1:0]        low, quo;
  logic [4:0]            cnt;

  logic [64:0]           rb_sum;
  logic                  ge;
  logic [63:0]           r_next;
  logic [61:0]           numer;
  logic [LEN_W:0]        trial;
  logic                  qbit;
  logic [LEN_W-1:0]      rem_next;
  logic [Q_W-1:0]        quo_next;
  logic [Q_W-1:0]        q_lim;
  logic [Q_W-1:0]        q_fin;
  logic [V_W-2:0]        cur_mag;

  assign done    = (state == U_DONE);
  assign sum_sq  = sum;
  assign cur_mag = mag[idx];

  // square root step
  always_comb begin
    rb_sum = {1'b0, r} + {1'b0, b};
    ge     = ({1'b0, x} >= rb_sum);
    r_next = ge ? ((r >> 1) + b) : (r >> 1);
  end

  // divide step and clamp
  always_comb begin
    numer    = (62'(cur_mag) << (fhi ? 36 : 20)) + 62'(len >> 1);
    trial    = {rem, low[Q_W-1]};
    qbit     = (trial >= {1'b0, len});
    rem_next = qbit ? LEN_W'(trial - {1'b0, len}) : trial[LEN_W-1:0];
    quo_next = {quo[Q_W-2:0], qbit};
    q_lim    = fhi ? (Q_W'(1) << 30) : (Q_W'(1) << 14);
    q_fin    = (quo_next > q_lim) ? q_lim : quo_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
    end else begin
      case (state)
        U_IDLE: begin
          if (req.start) begin
            for (int c = 0; c < 3; c++) begin
              neg[c] <= vec_in[c][V_W-1];
              mag[c] <= vec_in[c][V_W-1] ? (V_W-1)'(-$signed(vec_in[c]))
                                         : vec_in[c][V_W-2:0];
            end
            fhi   <= req.frac_hi;
            sum   <= '0;
            idx   <= 2'd0;
            state <= U_SQ;
          end
        end
        U_SQ: begin
          sum <= sum + SUM_W'(cur_mag) * SUM_W'(cur_mag);
          if (idx == 2'd2) begin
            state <= U_RINIT;
          end else begin
            idx <= idx + 2'd1;
          end
        end
        U_RINIT: begin
          if (sum == '0) begin
            vec_out <= '0;
            state   <= U_DONE;
          end else begin
            x     <= {sum, 12'b0};
            r     <= '0;
            b     <= 64'd1 << 62;
            cnt   <= '0;
            state <= U_ROOT;
          end
        end
        U_ROOT: begin
          if (ge) begin
            x <= x - rb_sum[63:0];
          end
          r   <= r_next;
          b   <= b >> 2;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            len   <= r_next[LEN_W-1:0];
            idx   <= 2'd0;
            state <= U_DLOAD;
          end
        end
        U_DLOAD: begin
          rem   <= fhi ? LEN_W'(numer >> 31) : LEN_W'(numer >> 15);
          low   <= fhi ? numer[30:0] : {numer[14:0], 16'b0};
          quo   <= '0;
          cnt   <= fhi ? 5'd30 : 5'd14;
          state <= U_DIV;
        end
        U_DIV: begin
          rem <= rem_next;
          low <= low << 1;
          quo <= quo_next;
          if (cnt == 5'd0) begin
            vec_out[idx] <= neg[idx] ? U_W'(-$signed({1'b0, q_fin}))
                                     : U_W'(q_fin);
            if (idx == 2'd2) begin
              state <= U_DONE;
            end else begin
              idx   <= idx + 2'd1;
              state <= U_DLOAD;
            end
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        U_DONE: begin
          state <= U_IDLE;
        end
        default: begin
          state <= U_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/ett_front.sv
`default_nettype none
module ett_front
  import ett_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire hdr_t                  in_word,
  input  wire logic [SCL_W-1:0]      width_scale,
  input  wire logic [SCL_W-1:0]      height_scale,
  output unit_req_t                  unit_req,
  output logic [2:0][V_W-1:0]        unit_vec,
  input  wire logic                  unit_done,
  input  wire logic [SUM_W-1:0]      unit_sum,
  input  wire logic [2:0][U_W-1:0]   unit_out,
  output q_push_t                    q_push,
  input  wire q_full_t               q_full,
  output ring_t                      ring_data,
  output hdr_t                       hdr_data
);

  front_state_t state, state_next;

  logic              buf_valid;
  hdr_t              in_buf;
  hdr_t              hdr;
  logic signed [D_W-1:0] d [3];
  logic signed [U_W-1:0] ax [3];
  logic signed [U_W-1:0] sd [3];
  logic signed [U_W-1:0] up [3];
  logic [SUM_W-1:0]  s;
  logic [47:0]       ysq;
  logic [2:0][V_W-1:0] uvec;
  logic              ustart, ufrac;
  logic [SEG_W-1:0]  k;
  logic [1:0]        i;
  logic signed [31:0] cw, sh, ch, sw;
  logic signed [63:0] p0, p1, p2, p3;
  logic [2:0][DIR_W-1:0] dir;

  logic signed [D_W-1:0] d_in [3];
  logic              d_zero;
  logic [D_W-2:0]    dy_mag;
  logic              vert;
  logic [1:0]        ia1, ib1, ia2, ib2;
  logic signed [63:0] up_diff;
  logic signed [63:0] sum_dir, sum_nrm;
  logic [TAB_W-1:0]  ti;
  logic signed [31:0] wxs, hxs;

  assign in_ready   = !buf_valid;
  assign unit_req   = '{start: ustart, frac_hi: ufrac};
  assign unit_vec   = uvec;
  assign hdr_data   = hdr;
  assign ring_data.dir = dir;
  assign q_push.ring_push = (state == F_RPUSH) && !q_full.ring_full;
  assign q_push.hdr_push  = (state == F_HDR) && !q_full.hdr_full;

  // difference vector of the buffered tube
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      d_in[c] = D_W'($signed(in_buf.en[c])) - D_W'($signed(in_buf.st[c]));
    end
    d_zero = (d_in[0] == '0) && (d_in[1] == '0) && (d_in[2] == '0);
    dy_mag = d[1][D_W-1] ? (D_W-1)'(-d[1]) : d[1][D_W-2:0];
    vert   = !((66'(ysq) * 66'd10000) < (66'(s) * 66'd9801));
  end

  // cross product terms for up
  always_comb begin
    case (i)
      2'd0:    begin ia1 = 2'd1; ib1 = 2'd2; ia2 = 2'd2; ib2 = 2'd1; end
      2'd1:    begin ia1 = 2'd2; ib1 = 2'd0; ia2 = 2'd0; ib2 = 2'd2; end
      default: begin ia1 = 2'd0; ib1 = 2'd1; ia2 = 2'd1; ib2 = 2'd0; end
    endcase
    up_diff = (64'(ax[ia1]) * 64'(sd[ib1])) - (64'(ax[ia2]) * 64'(sd[ib2]));
  end

  // ring scale terms
  always_comb begin
    ti      = tab_idx(k);
    wxs     = $signed({16'b0, width_scale});
    hxs     = $signed({16'b0, height_scale});
    sum_dir = p0 + p1;
    sum_nrm = p2 + p3;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:   if (buf_valid && !d_zero) state_next = F_AXIS;
      F_AXIS:   if (unit_done) state_next = F_CMP;
      F_CMP:    state_next = F_SIDE;
      F_SIDE:   if (unit_done) state_next = F_UP;
      F_UP:     if (i == 2'd2) state_next = F_RSCALE;
      F_RSCALE: state_next = F_RMUL;
      F_RMUL:   state_next = F_RADD;
      F_RADD:   state_next = (i == 2'd2) ? F_RNORM : F_RMUL;
      F_RNORM:  if (unit_done) state_next = F_RPUSH;
      F_RPUSH: begin
        if (!q_full.ring_full) begin
          state_next = (k == SEG_W'(SEG - 1)) ? F_HDR : F_RSCALE;
        end
      end
      F_HDR:    if (!q_full.hdr_full) state_next = F_IDLE;
      default:  state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      buf_valid <= 1'b0;
      ustart    <= 1'b0;
    end else begin
      state  <= state_next;
      ustart <= 1'b0;
      // input word buffer
      if (in_valid && in_ready) begin
        buf_valid <= 1'b1;
      end else if (state == F_IDLE && buf_valid) begin
        buf_valid <= 1'b0;
      end
      case (state)
        F_IDLE: begin
          if (buf_valid && !d_zero) begin
            ustart <= 1'b1;
          end
        end
        F_CMP: begin
          ustart <= 1'b1;
        end
        F_RADD: begin
          if (i == 2'd2) begin
            ustart <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_buf <= in_word;
    end
    case (state)
      F_IDLE: begin
        hdr   <= in_buf;
        ufrac <= 1'b1;
        for (int c = 0; c < 3; c++) begin
          d[c]    <= d_in[c];
          uvec[c] <= V_W'(d_in[c]);
        end
      end
      F_AXIS: begin
        if (unit_done) begin
          for (int c = 0; c < 3; c++) ax[c] <= $signed(unit_out[c]);
          s   <= unit_sum;
          ysq <= 48'(dy_mag) * 48'(dy_mag);
        end
      end
      F_CMP: begin
        if (vert) begin
          uvec[0] <= '0;
          uvec[1] <= V_W'(-d[2]);
          uvec[2] <= V_W'(d[1]);
        end else begin
          uvec[0] <= V_W'(d[2]);
          uvec[1] <= '0;
          uvec[2] <= V_W'(-d[0]);
        end
      end
      F_SIDE: begin
        if (unit_done) begin
          for (int c = 0; c < 3; c++) sd[c] <= $signed(unit_out[c]);
          i <= 2'd0;
        end
      end
      F_UP: begin
        up[i] <= U_W'(rnd64(up_diff, 30));
        i     <= (i == 2'd2) ? 2'd0 : i + 2'd1;
        if (i == 2'd2) k <= '0;
      end
      F_RSCALE: begin
        cw <= 32'(COS_TAB[ti]) * wxs;
        sh <= 32'(SIN_TAB[ti]) * hxs;
        ch <= 32'(COS_TAB[ti]) * hxs;
        sw <= 32'(SIN_TAB[ti]) * wxs;
        i  <= 2'd0;
      end
      F_RMUL: begin
        p0 <= 64'(cw) * 64'(sd[i]);
        p1 <= 64'(sh) * 64'(up[i]);
        p2 <= 64'(ch) * 64'(sd[i]);
        p3 <= 64'(sw) * 64'(up[i]);
      end
      F_RADD: begin
        dir[i]  <= DIR_W'(rnd64(sum_dir, 28));
        uvec[i] <= V_W'(rnd64(sum_nrm, 38));
        ufrac   <= 1'b0;
        i       <= i + 2'd1;
      end
      F_RNORM: begin
        if (unit_done) begin
          for (int c = 0; c < 3; c++) ring_data_nrm[c] <= unit_out[c][NRM_W-1:0];
        end
      end
      F_RPUSH: begin
        if (!q_full.ring_full) k <= k + SEG_W'(1);
      end
      default: begin
      end
    endcase
  end

  logic [2:0][NRM_W-1:0] ring_data_nrm;
  assign ring_data.nrm = ring_data_nrm;

endmodule
`default_nettype wire

>>> hdl/ett_queue.sv
`default_nettype none
module ett_queue
  import ett_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire q_push_t push,
  input  wire ring_t   ring_in,
  input  wire hdr_t    hdr_in,
  output q_full_t      full,
  input  wire q_pop_t  pop,
  output q_avail_t     avail,
  output ring_t        ring_head,
  output hdr_t         hdr_head
);

  localparam int RD = 16;
  localparam int RA = $clog2(RD);

  ring_t          ring_mem [RD];
  logic [RA-1:0]  ring_wr, ring_rd;
  logic [RA:0]    ring_cnt;

  hdr_t           hdr_mem [2];
  logic           hdr_wr, hdr_rd;
  logic [1:0]     hdr_cnt;

  assign full.ring_full  = (ring_cnt == (RA+1)'(RD));
  assign full.hdr_full   = (hdr_cnt == 2'd2);
  assign avail.ring_empty = (ring_cnt == '0);
  assign avail.hdr_valid  = (hdr_cnt != 2'd0);
  assign ring_head = ring_mem[ring_rd];
  assign hdr_head  = hdr_mem[hdr_rd];

  // ring point queue
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_wr  <= '0;
      ring_rd  <= '0;
      ring_cnt <= '0;
    end else begin
      if (push.ring_push) ring_wr <= ring_wr + RA'(1);
      if (pop.ring_pop)   ring_rd <= ring_rd + RA'(1);
      ring_cnt <= ring_cnt + (RA+1)'(push.ring_push) - (RA+1)'(pop.ring_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.ring_push) ring_mem[ring_wr] <= ring_in;
    if (push.hdr_push)  hdr_mem[hdr_wr]   <= hdr_in;
  end

  // tube header queue
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_wr  <= 1'b0;
      hdr_rd  <= 1'b0;
      hdr_cnt <= '0;
    end else begin
      if (push.hdr_push) hdr_wr <= !hdr_wr;
      if (pop.hdr_pop)   hdr_rd <= !hdr_rd;
      hdr_cnt <= hdr_cnt + 2'(push.hdr_push) - 2'(pop.hdr_pop);
    end
  end

endmodule
`default_nettype wire

>>> hdl/ett_back.sv
`default_nettype none
module ett_back
  import ett_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire q_avail_t           avail,
  input  wire ring_t              ring_head,
  input  wire hdr_t               hdr_head,
  output q_pop_t                  pop,
  input  wire logic [COL_W-1:0]   top_color,
  input  wire logic [COL_W-1:0]   bottom_color,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [POS_W-1:0]        pos_x,
  output logic [POS_W-1:0]        pos_y,
  output logic [POS_W-1:0]        pos_z,
  output logic [NRM_W-1:0]        norm_x,
  output logic [NRM_W-1:0]        norm_y,
  output logic [NRM_W-1:0]        norm_z,
  output logic [COL_W-1:0]        vertex_color,
  output logic                    last_vertex
);

  back_state_t state, state_next;
  ring_t            ra, rb, rfirst;
  logic [SEG_W-1:0] seg;
  logic [2:0]       j;

  logic             adv;
  logic             use_end, use_b;
  ring_t            rsel;
  logic [SEG_W-1:0] ridx;
  logic [R_W-1:0]   rad;
  logic [POS_W-1:0] base [3];
  logic signed [55:0] prod [3];
  logic [POS_W-1:0] pos [3];
  logic             seg_last, vtx_last;

  assign adv      = (state == B_EMIT) && (!out_valid || out_ready);
  assign seg_last = (seg == SEG_W'(SEG - 1));
  assign vtx_last = (j == 3'(VTX_PER_SEG - 1));

  // vertex order per segment: start@a end@a end@b start@a end@b start@b
  always_comb begin
    case (j)
      3'd1:    begin use_end = 1'b1; use_b = 1'b0; end
      3'd2:    begin use_end = 1'b1; use_b = 1'b1; end
      3'd4:    begin use_end = 1'b1; use_b = 1'b1; end
      3'd5:    begin use_end = 1'b0; use_b = 1'b1; end
      default: begin use_end = 1'b0; use_b = 1'b0; end
    endcase
    rsel = use_b ? rb : ra;
    ridx = use_b ? (seg_last ? '0 : seg + SEG_W'(1)) : seg;
    rad  = use_end ? hdr_head.r1 : hdr_head.r0;
    for (int c = 0; c < 3; c++) begin
      base[c] = use_end ? hdr_head.en[c] : hdr_head.st[c];
      prod[c] = 56'($signed(rsel.dir[c])) * $signed(56'({1'b0, rad}));
      pos[c]  = sat_pos(64'($signed(base[c])) + rnd64(64'(prod[c]), 30));
    end
  end

  // queue pops
  always_comb begin
    pop.ring_pop = 1'b0;
    pop.hdr_pop  = 1'b0;
    case (state)
      B_IDLE:   pop.ring_pop = avail.hdr_valid;
      B_SECOND: pop.ring_pop = 1'b1;
      B_EMIT: begin
        if (adv && vtx_last) begin
          pop.hdr_pop  = seg_last;
          pop.ring_pop = !seg_last && (seg + SEG_W'(2) != SEG_W'(SEG));
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:   if (avail.hdr_valid) state_next = B_SECOND;
      B_SECOND: state_next = B_EMIT;
      B_EMIT:   if (adv && vtx_last && seg_last) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ring registers and output word
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        ra     <= ring_head;
        rfirst <= ring_head;
      end
      B_SECOND: begin
        rb  <= ring_head;
        seg <= '0;
        j   <= '0;
      end
      B_EMIT: begin
        if (adv) begin
          if (vtx_last) begin
            j <= '0;
            if (!seg_last) begin
              seg <= seg + SEG_W'(1);
              ra  <= rb;
              rb  <= (seg + SEG_W'(2) == SEG_W'(SEG)) ? rfirst : ring_head;
            end
          end else begin
            j <= j + 3'd1;
          end
        end
      end
      default: begin
      end
    endcase
    if (adv) begin
      pos_x        <= pos[0];
      pos_y        <= pos[1];
      pos_z        <= pos[2];
      norm_x       <= rsel.nrm[0];
      norm_y       <= rsel.nrm[1];
      norm_z       <= rsel.nrm[2];
      vertex_color <= ((2 * int'(ridx)) < SEG) ? top_color : bottom_color;
      last_vertex  <= vtx_last && seg_last;
    end
  end

endmodule
`default_nettype wire

>>> hdl/elliptic_tube_tessellator_unit.sv
// channel  | handshake                  | word
// ---------+----------------------------+-------------------------------------------
// in       | in_valid / in_ready        | start_x/y/z, end_x/y/z, start/end_radius
// out      | out_valid / out_ready      | pos_x/y/z, norm_x/y/z, vertex_color, last_vertex
// cfg      | cfg_write (no back-pressure)| cfg_index, cfg_data
//
// in the front end, the shared normalise unit (square sum, square root, then a
// divide per component) runs twice for each tube's basis and once per ring point.
// the back end then emits the 60 vertices at one per cycle while out_ready allows,
// after a set-up that loads the first two ring points, from a 16 entry ring queue.
// a one word input buffer takes the next tube while the current one is worked on.
// reset is synchronous; the configuration registers reset to unit scales and white colours.
`default_nettype none
module elliptic_tube_tessellator_unit
  import ett_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [POS_W-1:0]   start_x,
  input  wire logic [POS_W-1:0]   start_y,
  input  wire logic [POS_W-1:0]   start_z,
  input  wire logic [POS_W-1:0]   end_x,
  input  wire logic [POS_W-1:0]   end_y,
  input  wire logic [POS_W-1:0]   end_z,
  input  wire logic [R_W-1:0]     start_radius,
  input  wire logic [R_W-1:0]     end_radius,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [POS_W-1:0]        pos_x,
  output logic [POS_W-1:0]        pos_y,
  output logic [POS_W-1:0]        pos_z,
  output logic [NRM_W-1:0]        norm_x,
  output logic [NRM_W-1:0]        norm_y,
  output logic [NRM_W-1:0]        norm_z,
  output logic [COL_W-1:0]        vertex_color,
  output logic                    last_vertex,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data
);

  logic [SCL_W-1:0] width_scale, height_scale;
  logic [COL_W-1:0] top_color, bottom_color;

  hdr_t                in_word;
  unit_req_t           unit_req;
  logic [2:0][V_W-1:0] unit_vec;
  logic                unit_done;
  logic [SUM_W-1:0]    unit_sum;
  logic [2:0][U_W-1:0] unit_out;
  q_push_t             q_push;
  q_full_t             q_full;
  q_pop_t              q_pop;
  q_avail_t            q_avail;
  ring_t               ring_data, ring_head;
  hdr_t                hdr_data, hdr_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_scale  <= SCL_W'(16384);
      height_scale <= SCL_W'(16384);
      top_color    <= {COL_W{1'b1}};
      bottom_color <= {COL_W{1'b1}};
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  width_scale  <= cfg_data[SCL_W-1:0];
        REG_HEIGHT: height_scale <= cfg_data[SCL_W-1:0];
        REG_TOP:    top_color    <= cfg_data[COL_W-1:0];
        REG_BOTTOM: bottom_color <= cfg_data[COL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_word.st = {start_z, start_y, start_x};
  assign in_word.en = {end_z, end_y, end_x};
  assign in_word.r0 = start_radius;
  assign in_word.r1 = end_radius;

  ett_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_word      (in_word),
    .width_scale  (width_scale),
    .height_scale (height_scale),
    .unit_req     (unit_req),
    .unit_vec     (unit_vec),
    .unit_done    (unit_done),
    .unit_sum     (unit_sum),
    .unit_out     (unit_out),
    .q_push       (q_push),
    .q_full       (q_full),
    .ring_data    (ring_data),
    .hdr_data     (hdr_data)
  );

  ett_unitize u_unitize (
    .clk     (clk),
    .rst     (rst),
    .req     (unit_req),
    .vec_in  (unit_vec),
    .done    (unit_done),
    .sum_sq  (unit_sum),
    .vec_out (unit_out)
  );

  ett_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .ring_in   (ring_data),
    .hdr_in    (hdr_data),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .ring_head (ring_head),
    .hdr_head  (hdr_head)
  );

  ett_back u_back (
    .clk          (clk),
    .rst          (rst),
    .avail        (q_avail),
    .ring_head    (ring_head),
    .hdr_head     (hdr_head),
    .pop          (q_pop),
    .top_color    (top_color),
    .bottom_color (bottom_color),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .norm_x       (norm_x),
    .norm_y       (norm_y),
    .norm_z       (norm_z),
    .vertex_color (vertex_color),
    .last_vertex  (last_vertex)
  );

`ifndef SYNTHESIS
  // front never writes a ring point into a full queue
  a_no_ring_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push.ring_push |-> !q_full.ring_full)
    else $error("ring point pushed into full queue");

  // back never reads a ring point that is not there
  a_no_ring_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop.ring_pop |-> !q_avail.ring_empty)
    else $error("ring point popped from empty queue");

  // a tube is retired exactly when its final vertex is loaded
  a_hdr_pop_last: assert property (@(posedge clk) disable iff (rst)
    q_pop.hdr_pop |=> out_valid && last_vertex)
    else $error("tube retired without final vertex");
`endif

endmodule
`default_nettype wire
